// ----- hdl/nfca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfca_pkg
// Shared types and constants of the next-fit chunk allocator.
// ----------------------------------------------------------------------------
package nfca_pkg;

    localparam int POOL_BYTES   = 1024;
    localparam int HEADER_BYTES = 16;
    localparam int FIELD_W      = 10;
    localparam int ADDR_W       = $clog2(POOL_BYTES);
    localparam int POS_W        = ADDR_W + 1;
    localparam int CNT_W        = ADDR_W;
    localparam int ALU_W        = ((ADDR_W > FIELD_W) ? ADDR_W : FIELD_W) + 3;

    localparam logic [ALU_W-1:0] HDR_A  = ALU_W'(HEADER_BYTES);
    localparam logic [ALU_W-1:0] POOL_A = ALU_W'(POOL_BYTES);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_FIT  = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic [ALU_W-1:0] c;
    } alu_req_t;

    typedef struct packed {
        logic             valid;
        logic             used;
        logic [CNT_W-1:0] count;
    } hdr_t;

    localparam int HDR_BITS = $bits(hdr_t);

endpackage

// ----- hdl/next_fit_chunk_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_chunk_allocator
// Allocate visits the chunk headers from the rover, wrapping to pool start once;
// free visits the headers from pool start up to the freed chunk, then merges
// free neighbors. One beat in flight at a time; header RAM read port sets
// pace. Reset: synchronous clear pass over every header RAM entry, no beat
// accepted until it ends. Rover returns to offset zero.
// ----------------------------------------------------------------------------
module next_fit_chunk_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_mode,
    input  logic [nfca_pkg::FIELD_W-1:0]   s_request_bytes,
    input  logic [nfca_pkg::FIELD_W-1:0]   s_chunk_offset,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [nfca_pkg::FIELD_W-1:0]   m_granted_offset,
    output logic [nfca_pkg::FIELD_W-1:0]   m_granted_bytes
);

    typedef enum logic [15:0] {
        S_CLR   = 16'h0001,
        S_IDLE  = 16'h0002,
        S_A_RD  = 16'h0004,
        S_A_CHK = 16'h0008,
        S_A_FND = 16'h0010,
        S_A_SPL = 16'h0020,
        S_A_UPD = 16'h0040,
        S_F_ADR = 16'h0080,
        S_F_HDR = 16'h0100,
        S_F_PRD = 16'h0200,
        S_F_PCK = 16'h0400,
        S_F_NXT = 16'h0800,
        S_F_NCK = 16'h1000,
        S_F_FIN = 16'h2000,
        S_DONE  = 16'h4000
    } state_t;

    localparam int AW = nfca_pkg::ADDR_W;
    localparam int PW = nfca_pkg::POS_W;
    localparam int CW = nfca_pkg::CNT_W;
    localparam int LW = nfca_pkg::ALU_W;
    localparam int FW = nfca_pkg::FIELD_W;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [FW-1:0]      req_reg, req_next;
    logic [FW-1:0]      off_reg, off_next;
    logic [PW-1:0]      p_reg, p_next;
    logic               pass_reg, pass_next;
    logic [PW-1:0]      base_reg, base_next;
    logic [PW-1:0]      h_reg, h_next;
    logic [PW-1:0]      nxt_reg, nxt_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               split_reg, split_next;
    logic [AW-1:0]      rover_reg, rover_next;
    nfca_pkg::status_t  res_status_reg, res_status_next;
    logic [FW-1:0]      res_goff_reg, res_goff_next;
    logic [FW-1:0]      res_gbytes_reg, res_gbytes_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [FW-1:0]      m_goff_reg, m_goff_next;
    logic [FW-1:0]      m_gbytes_reg, m_gbytes_next;

    nfca_pkg::alu_req_t             alu_req;
    logic [LW-1:0]                  alu_res;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    nfca_pkg::hdr_t                 wr_hdr;
    logic [AW-1:0]                  rd_addr;
    logic [nfca_pkg::HDR_BITS-1:0]  rd_data;
    nfca_pkg::hdr_t                 ent;
    logic [LW-1:0]                  ent_cnt_w;
    logic [LW-1:0]                  cnt_w;
    logic [LW-1:0]                  req_w;
    logic [CW-1:0]                  new_cnt;

    nfca_ram #(
        .WIDTH (nfca_pkg::HDR_BITS),
        .DEPTH (nfca_pkg::POOL_BYTES)
    ) u_hdr_ram (
        .aclk        (aclk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_hdr),
        .rd_addr     (rd_addr),
        .rd_data_reg (rd_data)
    );

    nfca_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    assign ent       = nfca_pkg::hdr_t'(rd_data);
    assign ent_cnt_w = LW'(ent.count);
    assign cnt_w     = LW'(cnt_reg);
    assign req_w     = LW'(req_reg);
    assign new_cnt   = split_reg ? CW'(req_reg) : cnt_reg;

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_granted_offset = m_goff_reg;
    assign m_granted_bytes  = m_gbytes_reg;

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        req_next        = req_reg;
        off_next        = off_reg;
        p_next          = p_reg;
        pass_next       = pass_reg;
        base_next       = base_reg;
        h_next          = h_reg;
        nxt_next        = nxt_reg;
        cnt_next        = cnt_reg;
        split_next      = split_reg;
        rover_next      = rover_reg;
        res_status_next = res_status_reg;
        res_goff_next   = res_goff_reg;
        res_gbytes_next = res_gbytes_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_status_next   = m_status_reg;
        m_goff_next     = m_goff_reg;
        m_gbytes_next   = m_gbytes_reg;
        alu_req         = '{op: nfca_pkg::ALU_ADD, a: '0, b: '0, c: '0};
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_hdr          = '0;
        rd_addr         = p_reg[AW-1:0];

        unique case (state_reg)
            S_CLR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                if (clr_reg == '0) begin
                    wr_hdr = '{valid: 1'b1, used: 1'b0,
                               count: CW'(nfca_pkg::POOL_BYTES - nfca_pkg::HEADER_BYTES)};
                end
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    req_next        = s_request_bytes;
                    off_next        = s_chunk_offset;
                    res_status_next = nfca_pkg::STATUS_OK;
                    res_goff_next   = '0;
                    res_gbytes_next = '0;
                    p_next          = PW'(rover_reg);
                    pass_next       = 1'b0;
                    state_next      = (s_mode == nfca_pkg::MODE_FREE) ? S_F_ADR : S_A_RD;
                end
            end
            S_A_RD: begin
                state_next = S_A_CHK;
            end
            S_A_CHK: begin
                alu_req = '{op: nfca_pkg::ALU_ADD, a: LW'(p_reg), b: nfca_pkg::HDR_A,
                            c: ent_cnt_w};
                if (!ent.used && ent_cnt_w >= req_w) begin
                    base_next  = p_reg;
                    cnt_next   = ent.count;
                    state_next = S_A_FND;
                end else if (!pass_reg) begin
                    if (alu_res < nfca_pkg::POOL_A) begin
                        p_next     = alu_res[PW-1:0];
                        state_next = S_A_RD;
                    end else if (rover_reg != '0) begin
                        pass_next  = 1'b1;
                        p_next     = '0;
                        state_next = S_A_RD;
                    end else begin
                        res_status_next = nfca_pkg::STATUS_NO_FIT;
                        state_next      = S_DONE;
                    end
                end else begin
                    if (alu_res < LW'(rover_reg)) begin
                        p_next     = alu_res[PW-1:0];
                        state_next = S_A_RD;
                    end else begin
                        res_status_next = nfca_pkg::STATUS_NO_FIT;
                        state_next      = S_DONE;
                    end
                end
            end
            S_A_FND: begin
                split_next = (cnt_w > req_w + nfca_pkg::HDR_A);
                alu_req    = '{op: nfca_pkg::ALU_ADD, a: LW'(base_reg), b: nfca_pkg::HDR_A,
                               c: (cnt_w > req_w + nfca_pkg::HDR_A) ? req_w : cnt_w};
                nxt_next   = alu_res[PW-1:0];
                state_next = (cnt_w > req_w + nfca_pkg::HDR_A) ? S_A_SPL : S_A_UPD;
            end
            S_A_SPL: begin
                alu_req = '{op: nfca_pkg::ALU_SUB, a: cnt_w, b: nfca_pkg::HDR_A, c: req_w};
                wr_en   = 1'b1;
                wr_addr = nxt_reg[AW-1:0];
                wr_hdr  = '{valid: 1'b1, used: 1'b0, count: alu_res[CW-1:0]};
                state_next = S_A_UPD;
            end
            S_A_UPD: begin
                alu_req = '{op: nfca_pkg::ALU_ADD, a: LW'(base_reg), b: nfca_pkg::HDR_A,
                            c: '0};
                wr_en   = 1'b1;
                wr_addr = base_reg[AW-1:0];
                wr_hdr  = '{valid: 1'b1, used: 1'b1, count: new_cnt};
                rover_next = (LW'(nxt_reg) < nfca_pkg::POOL_A) ? nxt_reg[AW-1:0] : '0;
                res_goff_next   = alu_res[FW-1:0];
                res_gbytes_next = FW'(new_cnt);
                state_next      = S_DONE;
            end
            S_F_ADR: begin
                alu_req = '{op: nfca_pkg::ALU_SUB, a: LW'(off_reg), b: nfca_pkg::HDR_A,
                            c: '0};
                rd_addr = alu_res[AW-1:0];
                h_next  = alu_res[PW-1:0];
                if (alu_res[LW-1] || alu_res >= nfca_pkg::POOL_A) begin
                    res_status_next = nfca_pkg::STATUS_INVALID;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_F_HDR;
                end
            end
            S_F_HDR: begin
                if (!ent.valid) begin
                    res_status_next = nfca_pkg::STATUS_INVALID;
                    state_next      = S_DONE;
                end else if (!ent.used) begin
                    state_next = S_DONE;
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = h_reg[AW-1:0];
                    wr_hdr   = '{valid: 1'b1, used: 1'b0, count: ent.count};
                    cnt_next = ent.count;
                    p_next   = '0;
                    base_next = h_reg;
                    state_next = (h_reg == '0) ? S_F_NXT : S_F_PRD;
                end
            end
            S_F_PRD: begin
                state_next = S_F_PCK;
            end
            S_F_PCK: begin
                alu_req = '{op: nfca_pkg::ALU_ADD, a: LW'(p_reg), b: nfca_pkg::HDR_A,
                            c: ent_cnt_w};
                if (alu_res >= LW'(h_reg)) begin
                    if (!ent.used) begin
                        base_next = p_reg;
                        cnt_next  = ent.count;
                    end
                    state_next = S_F_NXT;
                end else begin
                    p_next     = alu_res[PW-1:0];
                    state_next = S_F_PRD;
                end
            end
            S_F_NXT: begin
                alu_req = '{op: nfca_pkg::ALU_ADD, a: LW'(base_reg), b: nfca_pkg::HDR_A,
                            c: cnt_w};
                rd_addr = alu_res[AW-1:0];
                p_next  = alu_res[PW-1:0];
                state_next = (alu_res >= nfca_pkg::POOL_A) ? S_F_FIN : S_F_NCK;
            end
            S_F_NCK: begin
                alu_req = '{op: nfca_pkg::ALU_ADD, a: cnt_w, b: nfca_pkg::HDR_A,
                            c: ent_cnt_w};
                if (!ent.used) begin
                    cnt_next   = alu_res[CW-1:0];
                    wr_en      = 1'b1;
                    wr_addr    = p_reg[AW-1:0];
                    wr_hdr     = '0;
                    state_next = S_F_NXT;
                end else begin
                    state_next = S_F_FIN;
                end
            end
            S_F_FIN: begin
                wr_en      = 1'b1;
                wr_addr    = base_reg[AW-1:0];
                wr_hdr     = '{valid: 1'b1, used: 1'b0, count: cnt_reg};
                rover_next = base_reg[AW-1:0];
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_goff_next   = res_goff_reg;
                    m_gbytes_next = res_gbytes_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            rover_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            rover_reg   <= rover_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        off_reg        <= off_next;
        p_reg          <= p_next;
        pass_reg       <= pass_next;
        base_reg       <= base_next;
        h_reg          <= h_next;
        nxt_reg        <= nxt_next;
        cnt_reg        <= cnt_next;
        split_reg      <= split_next;
        res_status_reg <= res_status_next;
        res_goff_reg   <= res_goff_next;
        res_gbytes_reg <= res_gbytes_next;
        m_status_reg   <= m_status_next;
        m_goff_reg     <= m_goff_next;
        m_gbytes_reg   <= m_gbytes_next;
    end

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside done state");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLR) |-> !s_ready)
        else $error("input beat accepted during header clear");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_status_reg <= nfca_pkg::STATUS_INVALID))
        else $error("undefined status code on result beat");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != nfca_pkg::STATUS_OK)
            |-> (m_goff_reg == '0 && m_gbytes_reg == '0))
        else $error("failed request carries nonzero grant");

endmodule

// ----- hdl/nfca_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfca_ram
// Generic RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module nfca_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ----- hdl/nfca_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfca_alu
// Shared three-operand adder/subtractor used for every header walk step.
// ----------------------------------------------------------------------------
module nfca_alu (
    input  nfca_pkg::alu_req_t          req,
    output logic [nfca_pkg::ALU_W-1:0]  res
);

    always_comb begin
        unique case (req.op)
            nfca_pkg::ALU_ADD: res = req.a + req.b + req.c;
            nfca_pkg::ALU_SUB: res = req.a - req.b - req.c;
            default:           res = req.a;
        endcase
    end

endmodule

// ----- tb/sv/next_fit_chunk_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_chunk_allocator_tb
// Drives allocate and free requests into the chunk allocator and checks each
// response beat against a behavioral model of the chunk pool kept here.
// ----------------------------------------------------------------------------
module next_fit_chunk_allocator_tb;

    typedef struct packed {
        logic [1:0]                   status;
        logic [nfca_pkg::FIELD_W-1:0] goff;
        logic [nfca_pkg::FIELD_W-1:0] gbytes;
    } grant_t;

    localparam int HOLD_LEN = 400;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic                         s_mode = nfca_pkg::MODE_ALLOC;
    logic [nfca_pkg::FIELD_W-1:0] s_request_bytes = '0;
    logic [nfca_pkg::FIELD_W-1:0] s_chunk_offset = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [1:0]                   m_status;
    logic [nfca_pkg::FIELD_W-1:0] m_granted_offset;
    logic [nfca_pkg::FIELD_W-1:0] m_granted_bytes;

    next_fit_chunk_allocator dut (.*);

    always #5 aclk = ~aclk;

    // pool model
    logic         hv [nfca_pkg::POOL_BYTES];
    logic         hu [nfca_pkg::POOL_BYTES];
    int unsigned  hc [nfca_pkg::POOL_BYTES];
    int unsigned  rov;
    int unsigned  live_chunks[$];

    grant_t       grant_queue[$];
    int           mismatches = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    logic         hold_go = 1'b0;
    int           hold_cnt = 0;
    longint       cycle_count = 0;

    function automatic int unsigned nxt_hdr(int unsigned h);
        return h + nfca_pkg::HEADER_BYTES + hc[h];
    endfunction

    function automatic int unsigned prev_hdr(int unsigned h);
        int unsigned p;
        int unsigned pr;
        p = 0;
        pr = nfca_pkg::POOL_BYTES;
        while (p < h && p < nfca_pkg::POOL_BYTES) begin
            pr = p;
            p = nxt_hdr(p);
        end
        return pr;
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i < nfca_pkg::POOL_BYTES; i++) begin
            hv[i] = 1'b0;
            hu[i] = 1'b0;
            hc[i] = 0;
        end
        hv[0] = 1'b1;
        hc[0] = nfca_pkg::POOL_BYTES - nfca_pkg::HEADER_BYTES;
        rov = 0;
        live_chunks.delete();
    endfunction

    function automatic grant_t pool_apply(logic mode, int unsigned req, int unsigned off);
        grant_t      g;
        int unsigned found;
        int unsigned p;
        int unsigned h;
        int unsigned m;
        int unsigned pv;
        int unsigned nx;
        g = '0;
        g.status = nfca_pkg::STATUS_OK;
        if (mode == nfca_pkg::MODE_ALLOC) begin
            found = nfca_pkg::POOL_BYTES;
            p = rov;
            while (p < nfca_pkg::POOL_BYTES) begin
                if (!hu[p] && hc[p] >= req) begin
                    found = p;
                    break;
                end
                p = nxt_hdr(p);
            end
            if (found >= nfca_pkg::POOL_BYTES) begin
                p = 0;
                while (p < rov && p < nfca_pkg::POOL_BYTES) begin
                    if (!hu[p] && hc[p] >= req) begin
                        found = p;
                        break;
                    end
                    p = nxt_hdr(p);
                end
            end
            if (found >= nfca_pkg::POOL_BYTES) begin
                g.status = nfca_pkg::STATUS_NO_FIT;
            end else begin
                hu[found] = 1'b1;
                if (hc[found] > req + nfca_pkg::HEADER_BYTES) begin
                    h = found + nfca_pkg::HEADER_BYTES + req;
                    hv[h] = 1'b1;
                    hu[h] = 1'b0;
                    hc[h] = hc[found] - nfca_pkg::HEADER_BYTES - req;
                    hc[found] = req;
                end
                nx = nxt_hdr(found);
                rov = (nx < nfca_pkg::POOL_BYTES) ? nx : 0;
                g.goff = nfca_pkg::FIELD_W'(found + nfca_pkg::HEADER_BYTES);
                g.gbytes = nfca_pkg::FIELD_W'(hc[found]);
                live_chunks.push_back(found + nfca_pkg::HEADER_BYTES);
            end
        end else if (off < nfca_pkg::HEADER_BYTES) begin
            g.status = nfca_pkg::STATUS_INVALID;
        end else begin
            h = off - nfca_pkg::HEADER_BYTES;
            if (h >= nfca_pkg::POOL_BYTES || !hv[h]) begin
                g.status = nfca_pkg::STATUS_INVALID;
            end else if (hu[h]) begin
                hu[h] = 1'b0;
                m = h;
                forever begin
                    pv = prev_hdr(m);
                    if (pv >= nfca_pkg::POOL_BYTES || hu[pv]) break;
                    m = pv;
                end
                nx = nxt_hdr(m);
                while (nx < nfca_pkg::POOL_BYTES && !hu[nx]) begin
                    hc[m] += nfca_pkg::HEADER_BYTES + hc[nx];
                    hv[nx] = 1'b0;
                    hc[nx] = 0;
                    nx = nxt_hdr(m);
                end
                rov = m;
            end
        end
        return g;
    endfunction

    task automatic send_request(logic mode, int unsigned req, int unsigned off);
        @(posedge aclk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_request_bytes <= nfca_pkg::FIELD_W'(req);
        s_chunk_offset <= nfca_pkg::FIELD_W'(off);
        grant_queue.push_back(pool_apply(mode, req, off));
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
    endtask

    task automatic free_random_live();
        int idx;
        if (live_chunks.size() == 0) return;
        idx = $urandom_range(live_chunks.size() - 1);
        send_request(nfca_pkg::MODE_FREE, $urandom, live_chunks[idx]);
        live_chunks.delete(idx);
    endtask

    // response checker
    always @(posedge aclk) begin
        grant_t got;
        grant_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_granted_offset, m_granted_bytes};
            if (grant_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: %p", got);
            end else begin
                want = grant_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d off=%0d bytes=%0d got st=%0d off=%0d bytes=%0d",
                                 want.status, want.goff, want.gbytes,
                                 got.status, got.goff, got.gbytes);
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        if (hold_go && hold_cnt < HOLD_LEN) begin
            hold_cnt <= hold_cnt + 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (grant_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_request(nfca_pkg::MODE_FREE, 0, 0);
        send_request(nfca_pkg::MODE_FREE, 0, nfca_pkg::HEADER_BYTES - 1);
        send_request(nfca_pkg::MODE_FREE, 0, 1023);
        send_request(nfca_pkg::MODE_FREE, 0, nfca_pkg::HEADER_BYTES);  // free of a free chunk
        send_request(nfca_pkg::MODE_ALLOC, 1023, 0);                   // nothing fits
        send_request(nfca_pkg::MODE_ALLOC, nfca_pkg::POOL_BYTES - nfca_pkg::HEADER_BYTES, 0);
        send_request(nfca_pkg::MODE_ALLOC, 0, 0);
        send_request(nfca_pkg::MODE_FREE, 0, nfca_pkg::HEADER_BYTES);
        send_request(nfca_pkg::MODE_ALLOC, 0, 0);                      // zero request splits
        send_request(nfca_pkg::MODE_ALLOC, 100, 0);
        send_request(nfca_pkg::MODE_FREE, 0, nfca_pkg::HEADER_BYTES + 5);  // inside a chunk
        send_request(nfca_pkg::MODE_ALLOC, 200, 0);
        send_request(nfca_pkg::MODE_ALLOC, 50, 0);
        send_request(nfca_pkg::MODE_FREE, 0, 2 * nfca_pkg::HEADER_BYTES + 100);
        send_request(nfca_pkg::MODE_FREE, 0, nfca_pkg::HEADER_BYTES);
        send_request(nfca_pkg::MODE_ALLOC, 1000, 0);
        send_request(nfca_pkg::MODE_FREE, 0, 3 * nfca_pkg::HEADER_BYTES + 300);
        send_request(nfca_pkg::MODE_ALLOC, 3, 0);
        while (live_chunks.size() != 0) free_random_live();
        wait_drained();
    endtask

    task automatic test_random(int n);
        int unsigned r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 50)
                send_request(nfca_pkg::MODE_ALLOC,
                             ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                      : $urandom_range(120),
                             $urandom);
            else if (r < 85 && live_chunks.size() != 0)
                free_random_live();
            else
                send_request(nfca_pkg::MODE_FREE, $urandom, $urandom_range(1023));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_go <= 1'b1;
        for (int i = 0; i < 20; i++) begin
            send_request(nfca_pkg::MODE_ALLOC, $urandom_range(40), 0);
        end
        wait_drained();
    endtask

    initial begin
        pool_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 17;
        recv_idle_pct = 52;
        test_directed();
        test_random(550);
        test_backpressure();
        send_idle_pct = 52;
        recv_idle_pct = 17;
        test_random(550);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(560);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
